### rtl/core/rtc3w_pkg.sv
`timescale 1ns / 1ps

package rtc3w_pkg;

    // Tick counter values of the pin sequence.
    localparam logic [5:0] STEP_IDLE      = 6'd0;
    localparam logic [5:0] STEP_FIRST     = 6'd1;
    localparam logic [5:0] STEP_CMD_LAST  = 6'd16;
    localparam logic [5:0] STEP_DATA_BASE = 6'd17;
    localparam logic [5:0] STEP_DATA_LAST = 6'd32;
    localparam logic [5:0] STEP_END       = 6'd33;

    // Command byte base; the read flag sits in bit zero.
    localparam logic [7:0] CMD_BASE = 8'h80;

    // Field codes.
    localparam logic [2:0] FIELD_WEEKDAY = 3'd5;
    localparam logic [2:0] FIELD_INVALID = 3'd7;

    // Access modes.
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Largest decoded value.
    localparam logic [6:0] VALUE_MAX = 7'd99;

    // Tens nibble mask for each time field.
    function automatic logic [3:0] tens_mask(input logic [2:0] fld);
        logic [3:0] m;
        begin
            case (fld)
                3'd0:    m = 4'h7;
                3'd1:    m = 4'h7;
                3'd2:    m = 4'h3;
                3'd3:    m = 4'h3;
                3'd4:    m = 4'h1;
                3'd5:    m = 4'h0;
                3'd6:    m = 4'hf;
                default: m = 4'h7;
            endcase
            return m;
        end
    endfunction

    // Units nibble mask: weekday only uses three bits.
    function automatic logic [3:0] units_mask(input logic [2:0] fld);
        return (fld == FIELD_WEEKDAY) ? 4'h7 : 4'hf;
    endfunction

endpackage

### rtl/core/rtc_three_wire_field_access.sv
`timescale 1ns / 1ps

// Master for a three-wire real-time-clock link, one time field per transaction.
// Input channel (s_): one transaction per half-bit tick. It carries the request
// fields (start, mode, field, value) and the sampled data pin level. A start is
// acted on only while idle; the request is then held for the whole access.
// Result channel (m_): exactly one transaction per input transaction, carrying
// the pin levels for that tick plus busy, done and the last decoded read value.
// An access takes 33 ticks: 16 for the command byte, 16 for the data byte and
// one closing tick on which done pulses.
// Results show the cycle after their tick; one tick is accepted every cycle
// as long as the result register is empty or being drained, since all the work
// is one short combinational pass between the tick and the result register.
// When the receiver stalls, the result is held and s_tready drops until the
// held result is taken; no state advances without an accepted tick.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears the
// held request, the shift bytes and the read value, and empties the result
// register.
module rtc_three_wire_field_access (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: start_req[0], mode[1], field[4:2], value[11:5], dio_in[12], zero[15:13]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: chip_enable[0], serial_clock[1], dio_out[2], dio_drive[3], busy_res[4],
    //        done_res[5], read_value[12:6], zero[15:13]
    output logic [15:0] m_tdata
);
    import rtc3w_pkg::*;

    // Sequencer and request state.
    logic [5:0] step_reg, step_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] wbyte_reg, wbyte_next;
    logic [7:0] rbyte_reg, rbyte_next;
    logic       mode_reg, mode_next;
    logic [2:0] field_reg, field_next;
    logic [6:0] last_reg, last_next;

    // Result register.
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic [15:0] out_data_next;

    // Unpacked input fields.
    logic       in_start;
    logic       in_mode;
    logic [2:0] in_field;
    logic [6:0] in_value;
    logic       in_dio;

    logic       s_acc;
    logic       take_start;
    logic [5:0] step_eff;
    logic [5:0] step_off;
    logic [2:0] bit_idx;
    logic       half;

    // Binary to BCD of the write value: divide by ten through a reciprocal.
    logic [14:0] tens_prod;
    logic [3:0]  val_tens;
    logic [7:0]  tens_times10;
    logic [3:0]  val_units;

    // Reply decode.
    logic [3:0] dec_tens;
    logic [3:0] dec_units;
    logic [7:0] dec_sum;

    logic ce, sck, dout, drv, busy, done;

    assign in_start = s_tdata[0];
    assign in_mode  = s_tdata[1];
    assign in_field = s_tdata[4:2];
    assign in_value = s_tdata[11:5];
    assign in_dio   = s_tdata[12];

    assign s_tready = !out_valid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;

    assign tens_prod    = {8'd0, in_value} * 15'd205;
    assign val_tens     = tens_prod[14:11];
    assign tens_times10 = {1'b0, val_tens, 3'b000} + {3'b000, val_tens, 1'b0};
    assign val_units    = 4'(({1'b0, in_value} - tens_times10));

    assign dec_tens  = rbyte_reg[7:4] & tens_mask(field_reg);
    assign dec_units = rbyte_reg[3:0] & units_mask(field_reg);
    assign dec_sum   = {1'b0, dec_tens, 3'b000} + {3'b000, dec_tens, 1'b0} + {4'd0, dec_units};

    // Next state and pin levels for one tick.
    always_comb begin
        take_start = (step_reg == STEP_IDLE) && in_start && (in_field != FIELD_INVALID);
        step_eff   = take_start ? STEP_FIRST : step_reg;
        mode_next  = take_start ? in_mode : mode_reg;
        field_next = take_start ? in_field : field_reg;
        shift_next = take_start
            ? (CMD_BASE + {4'd0, in_field, 1'b0} + {7'd0, (in_mode == MODE_READ)})
            : shift_reg;
        wbyte_next = take_start ? {val_tens, val_units} : wbyte_reg;
        rbyte_next = take_start ? 8'd0 : rbyte_reg;
        last_next  = last_reg;
        step_next  = STEP_IDLE;

        ce   = 1'b0;
        sck  = 1'b0;
        dout = 1'b0;
        drv  = 1'b1;
        busy = 1'b0;
        done = 1'b0;

        if (step_eff >= STEP_DATA_BASE) begin
            step_off = step_eff - STEP_DATA_BASE;
        end else begin
            step_off = step_eff - STEP_FIRST;
        end
        bit_idx = step_off[3:1];
        half    = step_off[0];

        if (step_eff >= STEP_FIRST && step_eff <= STEP_CMD_LAST) begin
            // Command byte, LSB first, data set up while the clock is low.
            ce        = 1'b1;
            busy      = 1'b1;
            sck       = half;
            dout      = shift_next[bit_idx];
            step_next = step_eff + 6'd1;
        end else if (step_eff >= STEP_DATA_BASE && step_eff <= STEP_DATA_LAST) begin
            ce        = 1'b1;
            busy      = 1'b1;
            step_next = step_eff + 6'd1;
            if (mode_next == MODE_WRITE) begin
                sck  = half;
                dout = wbyte_next[bit_idx];
            end else begin
                // Released pin; sample after each falling clock.
                drv = 1'b0;
                if (half) begin
                    rbyte_next[bit_idx] = rbyte_next[bit_idx] | in_dio;
                    sck = (bit_idx != 3'd7);
                end
            end
        end else if (step_eff == STEP_END) begin
            done = 1'b1;
            if (mode_next == MODE_READ) begin
                last_next = (dec_sum > {1'b0, VALUE_MAX}) ? VALUE_MAX : dec_sum[6:0];
            end
        end

        out_data_next = {3'b000, last_next, done, busy, drv, dout, sck, ce};
    end

    // State advances only on an accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_IDLE;
            shift_reg <= 8'd0;
            wbyte_reg <= 8'd0;
            rbyte_reg <= 8'd0;
            mode_reg  <= 1'b0;
            field_reg <= 3'd0;
            last_reg  <= 7'd0;
        end else if (s_acc) begin
            step_reg  <= step_next;
            shift_reg <= shift_next;
            wbyte_reg <= wbyte_next;
            rbyte_reg <= rbyte_next;
            mode_reg  <= mode_next;
            field_reg <= field_next;
            last_reg  <= last_next;
        end
    end

    // Result register with its valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_acc) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // The closing tick always returns the sequencer to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && step_reg == STEP_END |=> step_reg == STEP_IDLE)
        else $error("sequencer did not return to idle after the closing tick");

    // The counter never reaches codes beyond the closing tick.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_END)
        else $error("tick counter out of range");

    // A released data pin only happens inside an enabled read phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[0] && !m_tdata[2] && m_tdata[4])
        else $error("data pin released outside a read");

    // Done and busy are never raised together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> !m_tdata[4] && !m_tdata[0])
        else $error("done raised while busy or enabled");
`endif

endmodule
